@@ hdl/xxtea_pkg.sv @@
// Shared types, constants and the round mixing function for the XXTEA pipeline.
package xxtea_pkg;

   localparam logic [31:0] Delta = 32'h9E37_79B9;
   localparam int unsigned DefaultRounds = 19;
   localparam int unsigned WordsPerBlock = 4;
   localparam int unsigned CsrAddrWidth = 4;
   localparam int unsigned CsrDataWidth = 64;

   // Register select, taken from the 8-byte aligned address bit.
   localparam logic RegKeyHigh = 1'b0;
   localparam logic RegKeyLow = 1'b1;

   localparam logic ActEncrypt = 1'b0;
   localparam logic ActDecrypt = 1'b1;

   typedef logic [WordsPerBlock-1:0][31:0] block_type;

   typedef struct packed {
      logic      valid;
      logic      action;
      block_type word;
   } stage_type;

   function automatic logic [31:0] mix(input logic [31:0] y, input logic [31:0] z,
                                       input logic [31:0] sum, input logic [31:0] kw);
      logic [31:0] left;
      logic [31:0] right;
      begin
         left = ((z >> 5) ^ (y << 2)) + ((y >> 3) ^ (z << 4));
         right = (sum ^ y) + (kw ^ z);
         return left ^ right;
      end
   endfunction

endpackage

@@ hdl/xxtea_block_cipher.sv @@
// Top level of the pipelined XXTEA cipher: key registers, cell chain and output buffering.
//
//  channel   direction  handshake               payload
//  req_      in         req_valid / req_stall   req_action, req_block_high, req_block_low
//  rsp_      out        rsp_valid / rsp_stall   rsp_result_high, rsp_result_low
//  csr_      in/out     psel, penable, pready   paddr (4 bits), pwdata / prdata (64 bits)
//
// One block enters every cycle while req_stall is low; each passes 4*ROUNDS cells (one word
// update per cell, 76 cells at the default) and then the output register.
// Throughput is one block per cycle while req_stall is low.
// Reset (synchronous) clears the keys, all cell valid bits, and the output and skid valid bits.
// A held result fills the skid register with one more block; only then does req_stall
// rise and the whole chain freeze until the output is taken.
module xxtea_block_cipher #(
   parameter int unsigned ROUNDS = xxtea_pkg::DefaultRounds
) (
   input  logic                                  clock,
   input  logic                                  reset,
   // input channel
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic                                  req_action,
   input  logic [63:0]                           req_block_high,
   input  logic [63:0]                           req_block_low,
   // result channel
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic [63:0]                           rsp_result_high,
   output logic [63:0]                           rsp_result_low,
   // configuration port
   input  logic                                  csr_psel,
   input  logic                                  csr_penable,
   input  logic                                  csr_pwrite,
   input  logic [xxtea_pkg::CsrAddrWidth-1:0]    csr_paddr,
   input  logic [xxtea_pkg::CsrDataWidth-1:0]    csr_pwdata,
   output logic [xxtea_pkg::CsrDataWidth-1:0]    csr_prdata,
   output logic                                  csr_pready
);

   localparam int unsigned Stages = xxtea_pkg::WordsPerBlock * ROUNDS;

   // ---------------------------------------------------------------- key registers
   logic [63:0] key_high_ff;
   logic [63:0] key_low_ff;
   logic        csr_write;
   logic        csr_sel;

   assign csr_pready = 1'b1;
   assign csr_write = csr_psel && csr_penable && csr_pwrite && csr_pready;
   // Registers sit 8 bytes apart; the 8-byte bit picks the register.
   assign csr_sel = csr_paddr[3];

   always_ff @(posedge clock) begin
      if (reset) begin
         key_high_ff <= '0;
         key_low_ff <= '0;
      end else if (csr_write) begin
         unique case (csr_sel)
            xxtea_pkg::RegKeyHigh: key_high_ff <= csr_pwdata;
            xxtea_pkg::RegKeyLow:  key_low_ff <= csr_pwdata;
            default:               key_low_ff <= key_low_ff;
         endcase
      end
   end

   always_comb begin
      unique case (csr_sel)
         xxtea_pkg::RegKeyHigh: csr_prdata = key_high_ff;
         xxtea_pkg::RegKeyLow:  csr_prdata = key_low_ff;
         default:               csr_prdata = '0;
      endcase
   end

   // Key words 0..3, big-endian: word 0 is the top half of key_high.
   xxtea_pkg::block_type key_word;
   assign key_word = {key_low_ff[31:0], key_low_ff[63:32], key_high_ff[31:0], key_high_ff[63:32]};

   // ---------------------------------------------------------------- cell chain
   xxtea_pkg::stage_type stage_link [0:Stages];
   logic                 advance;
   logic                 skid_valid_ff;

   // The chain moves whenever the skid register is free to catch the last cell.
   assign advance = !skid_valid_ff;
   assign req_stall = skid_valid_ff;

   assign stage_link[0].valid = req_valid;
   assign stage_link[0].action = req_action;
   assign stage_link[0].word = {req_block_low[31:0], req_block_low[63:32],
                                req_block_high[31:0], req_block_high[63:32]};

   for (genvar j = 0; j < Stages; j++) begin : g_cell
      localparam int unsigned RoundIdx = j / xxtea_pkg::WordsPerBlock;
      localparam int unsigned Slot = j % xxtea_pkg::WordsPerBlock;
      // Running sum of this round: grows by delta when encrypting, counts down when decrypting.
      localparam logic [63:0] EncProd = 64'(RoundIdx + 1) * 64'(xxtea_pkg::Delta);
      localparam logic [63:0] DecProd = 64'(ROUNDS - RoundIdx) * 64'(xxtea_pkg::Delta);

      xxtea_cell #(
         .SLOT    (Slot),
         .ENC_SUM (EncProd[31:0]),
         .DEC_SUM (DecProd[31:0])
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .advance   (advance),
         .stage_in  (stage_link[j]),
         .key_word  (key_word),
         .stage_out (stage_link[j+1])
      );
   end

   // ---------------------------------------------------------------- output buffering
   logic        rsp_valid_ff;
   logic [63:0] rsp_high_ff;
   logic [63:0] rsp_low_ff;
   logic [63:0] skid_high_ff;
   logic [63:0] skid_low_ff;
   logic [63:0] done_high;
   logic [63:0] done_low;
   logic        done_valid;
   logic        rsp_take;

   assign done_high = {stage_link[Stages].word[0], stage_link[Stages].word[1]};
   assign done_low = {stage_link[Stages].word[2], stage_link[Stages].word[3]};
   // A finished block leaves the last cell only while the chain advances.
   assign done_valid = stage_link[Stages].valid && advance;
   assign rsp_take = rsp_valid_ff && !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         // Drain the skid into the output once the waiting result transfers.
         if (rsp_take) begin
            skid_valid_ff <= 1'b0;
         end
      end else if (done_valid) begin
         if (!rsp_valid_ff || rsp_take) begin
            rsp_valid_ff <= 1'b1;
         end else begin
            skid_valid_ff <= 1'b1;
         end
      end else if (rsp_take) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (skid_valid_ff) begin
         if (rsp_take) begin
            rsp_high_ff <= skid_high_ff;
            rsp_low_ff <= skid_low_ff;
         end
      end else if (done_valid) begin
         if (!rsp_valid_ff || rsp_take) begin
            rsp_high_ff <= done_high;
            rsp_low_ff <= done_low;
         end else begin
            skid_high_ff <= done_high;
            skid_low_ff <= done_low;
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_result_high = rsp_high_ff;
   assign rsp_result_low = rsp_low_ff;

   // ---------------------------------------------------------------- assertions
   // The skid only holds data behind a waiting result.
   a_skid_behind_rsp: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> rsp_valid_ff)
      else $error("skid register full while output register empty");

   // The skid fills only when the output was blocked.
   a_skid_fill_cause: assert property (@(posedge clock) disable iff (reset)
      $rose(skid_valid_ff) |-> $past(rsp_valid_ff && rsp_stall))
      else $error("skid register filled without a stalled result");

   // A block leaving the chain lands in the output or skid register; the output is valid next cycle.
   a_done_lands: assert property (@(posedge clock) disable iff (reset)
      done_valid |=> rsp_valid_ff)
      else $error("finished block dropped at the output");

   // A stalled result holds its value until it transfers.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_stall) |=> (rsp_valid_ff && $stable(rsp_high_ff)
                                      && $stable(rsp_low_ff)))
      else $error("stalled result changed");

endmodule

@@ hdl/xxtea_cell.sv @@
// One pipeline cell: a single word update of one XXTEA round, encrypt or decrypt.
module xxtea_cell #(
   parameter int unsigned SLOT = 0,
   parameter logic [31:0] ENC_SUM = 32'h0,
   parameter logic [31:0] DEC_SUM = 32'h0
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  advance,
   input  xxtea_pkg::stage_type  stage_in,
   input  xxtea_pkg::block_type  key_word,
   output xxtea_pkg::stage_type  stage_out
);

   // Encryption walks words 0..3 in a round, decryption walks 3..0.
   localparam logic [1:0] EncPos = 2'(SLOT);
   localparam logic [1:0] DecPos = 2'(3 - SLOT);

   logic [1:0]           pos;
   logic [31:0]          sum;
   logic [31:0]          mixed;
   xxtea_pkg::stage_type stage_in_w;
   logic                 valid_ff;
   logic                 action_ff;
   xxtea_pkg::block_type word_ff;

   always_comb begin
      pos = (stage_in.action == xxtea_pkg::ActDecrypt) ? DecPos : EncPos;
      sum = (stage_in.action == xxtea_pkg::ActDecrypt) ? DEC_SUM : ENC_SUM;
      mixed = xxtea_pkg::mix(stage_in.word[pos + 2'd1], stage_in.word[pos - 2'd1], sum,
                             key_word[pos ^ sum[3:2]]);
      stage_in_w = stage_in;
      if (stage_in.action == xxtea_pkg::ActDecrypt) begin
         stage_in_w.word[pos] = stage_in.word[pos] - mixed;
      end else begin
         stage_in_w.word[pos] = stage_in.word[pos] + mixed;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= stage_in_w.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         action_ff <= stage_in_w.action;
         word_ff <= stage_in_w.word;
      end
   end

   assign stage_out = '{valid: valid_ff, action: action_ff, word: word_ff};

endmodule

@@ tb/tb_top.sv @@
// Self-checking testbench for the pipelined XXTEA block cipher: stimulus, predictor, scoreboard.
module tb_top;

   localparam int unsigned CipherRounds = xxtea_pkg::DefaultRounds;
   // Cells in the chain plus the output register.
   localparam int unsigned PipeLatency = 4 * CipherRounds + 1;
   localparam int unsigned CycleLimit = 400000;
   localparam int unsigned RandomPerPhase = 585;
   localparam int unsigned MaxReported = 10;

   // The key registers are 64 bits wide, so they sit on 8-byte boundaries.
   localparam logic [xxtea_pkg::CsrAddrWidth-1:0] KeyHighAddr = {xxtea_pkg::RegKeyHigh, 3'b000};
   localparam logic [xxtea_pkg::CsrAddrWidth-1:0] KeyLowAddr = {xxtea_pkg::RegKeyLow, 3'b000};

   // Corner blocks: all zero, all one, alternating bits both ways, lone end bits.
   localparam bit [127:0] CornerBlocks [6] = '{
      128'h0,
      {128{1'b1}},
      {32{4'hA}},
      {32{4'h5}},
      {1'b1, 127'h0},
      {127'h0, 1'b1}
   };

   // ---------------------------------------------------------------------------------------
   // Scoreboard: holds its own copy of the key, predicts each block on acceptance, and
   // compares results in order against the oldest prediction.
   // ---------------------------------------------------------------------------------------
   class xxtea_scoreboard;
      bit [31:0]   key_word [4];
      bit [127:0]  expected_blocks [$];
      int unsigned mismatches;

      function void load_key(bit sel, bit [63:0] value);
         if (sel == xxtea_pkg::RegKeyHigh) begin
            key_word[0] = value[63:32];
            key_word[1] = value[31:0];
         end else begin
            key_word[2] = value[63:32];
            key_word[3] = value[31:0];
         end
      endfunction

      function bit [31:0] round_mix(bit [31:0] y, bit [31:0] z, bit [31:0] sum, bit [31:0] kw);
         return (((z >> 5) ^ (y << 2)) + ((y >> 3) ^ (z << 4))) ^ ((sum ^ y) + (kw ^ z));
      endfunction

      function bit [127:0] cipher_block(bit act, bit [127:0] blk);
         bit [31:0] v [4];
         bit [31:0] sum;
         bit [31:0] y;
         bit [31:0] z;
         bit [1:0]  e;
         v[0] = blk[127:96];
         v[1] = blk[95:64];
         v[2] = blk[63:32];
         v[3] = blk[31:0];
         if (act == xxtea_pkg::ActDecrypt) begin
            // Run the rounds backward from the final sum, wrapped to 32 bits.
            sum = CipherRounds * xxtea_pkg::Delta;
            y = v[0];
            for (int r = 0; r < CipherRounds; r++) begin
               e = sum[3:2];
               for (int p = 3; p > 0; p--) begin
                  z = v[p-1];
                  v[p] -= round_mix(y, z, sum, key_word[2'(p) ^ e]);
                  y = v[p];
               end
               v[0] -= round_mix(y, v[3], sum, key_word[e]);
               y = v[0];
               sum -= xxtea_pkg::Delta;
            end
         end else begin
            sum = '0;
            z = v[3];
            for (int r = 0; r < CipherRounds; r++) begin
               sum += xxtea_pkg::Delta;
               e = sum[3:2];
               for (int p = 0; p < 4; p++) begin
                  y = v[(p + 1) % 4];
                  v[p] += round_mix(y, z, sum, key_word[2'(p) ^ e]);
                  z = v[p];
               end
            end
         end
         return {v[0], v[1], v[2], v[3]};
      endfunction

      function void note_block(bit act, bit [63:0] hi, bit [63:0] lo);
         expected_blocks.push_back(cipher_block(act, {hi, lo}));
      endfunction

      function void flag_field(string field, bit [63:0] want, bit [63:0] got);
         mismatches++;
         if (mismatches <= MaxReported)
            $display("mismatch on %s: expected %h, got %h", field, want, got);
      endfunction

      function void check_result(bit [63:0] hi, bit [63:0] lo);
         bit [127:0] want;
         if (expected_blocks.size() == 0) begin
            mismatches++;
            if (mismatches <= MaxReported)
               $display("result %h_%h arrived with no block outstanding", hi, lo);
            return;
         end
         want = expected_blocks.pop_front();
         if (want[127:64] != hi)
            flag_field("result_high", want[127:64], hi);
         if (want[63:0] != lo)
            flag_field("result_low", want[63:0], lo);
      endfunction

      function int unsigned pending();
         return expected_blocks.size();
      endfunction

      function void close_out();
         if (expected_blocks.size() != 0) begin
            $display("%0d blocks never produced a result", expected_blocks.size());
            mismatches += expected_blocks.size();
         end
      endfunction
   endclass

   // ---------------------------------------------------------------------------------------
   // Signals. Every block input starts at a known value.
   // ---------------------------------------------------------------------------------------
   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic        req_action = xxtea_pkg::ActEncrypt;
   logic [63:0] req_block_high = '0;
   logic [63:0] req_block_low = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [63:0] rsp_result_high;
   logic [63:0] rsp_result_low;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [xxtea_pkg::CsrAddrWidth-1:0] csr_paddr = '0;
   logic [xxtea_pkg::CsrDataWidth-1:0] csr_pwdata = '0;
   logic [xxtea_pkg::CsrDataWidth-1:0] csr_prdata;
   logic        csr_pready;

   int unsigned sender_idle_pct = 0;
   int unsigned receiver_stall_pct = 0;
   int unsigned cycle_count = 0;

   xxtea_scoreboard sb = new();

   xxtea_block_cipher #(
      .ROUNDS(CipherRounds)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_action(req_action),
      .req_block_high(req_block_high),
      .req_block_low(req_block_low),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_result_high(rsp_result_high),
      .rsp_result_low(rsp_result_low),
      .csr_psel(csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr),
      .csr_pwdata(csr_pwdata),
      .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   always #1 clock = ~clock;

   // Watchdog: a hung pipeline or a lost transfer ends here.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CycleLimit) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   // Receiver: stall at random with the current phase's rate.
   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < receiver_stall_pct);
   end

   // Monitor: all drivers use nonblocking updates, so values read here are the ones that
   // were stable before this edge. Note each input transfer, check each result transfer.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall)
            sb.note_block(req_action, req_block_high, req_block_low);
         if (rsp_valid && !rsp_stall)
            sb.check_result(rsp_result_high, rsp_result_low);
      end
   end

   // ---------------------------------------------------------------------------------------
   // Drivers
   // ---------------------------------------------------------------------------------------

   // Present one block and hold it until the transfer happens; valid stays high on return
   // so a following block can go out back to back.
   task automatic send_block(input logic act, input logic [63:0] hi, input logic [63:0] lo);
      req_valid <= 1'b1;
      req_action <= act;
      req_block_high <= hi;
      req_block_low <= lo;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
   endtask

   // Sender gaps: drop valid for a random number of cycles at the phase's rate.
   task automatic sender_gap();
      while ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
   endtask

   // Drop valid and wait until every predicted block has come back.
   task automatic drain();
      req_valid <= 1'b0;
      while (sb.pending() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // Setup phase, then access phase; the key lands at the edge where pready is seen.
   task automatic write_key(input logic [xxtea_pkg::CsrAddrWidth-1:0] addr,
                            input logic [63:0] value);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= addr;
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready)
         @(posedge clock);
      sb.load_key(addr[3], value);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
   endtask

   // Words skewed toward all-zero and all-one so carries and borrows get exercised.
   function automatic logic [31:0] random_word();
      case ($urandom_range(9))
         0: return '0;
         1: return '1;
         default: return $urandom;
      endcase
   endfunction

   task automatic corner_sweep();
      for (int i = 0; i < 6; i++) begin
         sender_gap();
         send_block(xxtea_pkg::ActEncrypt, CornerBlocks[i][127:64], CornerBlocks[i][63:0]);
         sender_gap();
         send_block(xxtea_pkg::ActDecrypt, CornerBlocks[i][127:64], CornerBlocks[i][63:0]);
      end
   endtask

   // ---------------------------------------------------------------------------------------
   // Sequence
   // ---------------------------------------------------------------------------------------
   initial begin
      logic [63:0] key_a;
      logic [63:0] key_b;

      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Corner blocks under the reset key (all zero), then under the all-one key.
      sender_idle_pct = 9;
      receiver_stall_pct = 52;
      corner_sweep();
      drain();
      write_key(KeyHighAddr, '1);
      write_key(KeyLowAddr, '1);
      corner_sweep();

      // Random phases: sender-light / receiver-heavy, the reverse, then no idling at all.
      for (int phase = 0; phase < 3; phase++) begin
         drain();
         case (phase)
            0: begin
               sender_idle_pct = 9;
               receiver_stall_pct = 52;
               key_a = {$urandom, $urandom};
               key_b = {$urandom, $urandom};
            end
            1: begin
               sender_idle_pct = 52;
               receiver_stall_pct = 9;
               key_a = '0;
               key_b = {$urandom, $urandom};
            end
            default: begin
               sender_idle_pct = 0;
               receiver_stall_pct = 0;
               key_a = {$urandom, $urandom};
               key_b = '1;
            end
         endcase
         write_key(KeyHighAddr, key_a);
         write_key(KeyLowAddr, key_b);

         for (int n = 0; n < RandomPerPhase; n++) begin
            // Once, in the middle of the first phase, hold off until the pipeline has emptied completely.
            if (phase == 0 && n == RandomPerPhase / 2)
               drain();
            sender_gap();
            send_block(1'($urandom_range(1)), {random_word(), random_word()},
                       {random_word(), random_word()});
         end
      end

      // Wait out the outstanding blocks, then a quiet stretch longer than the pipeline latency so that
      // any spurious extra result would still be caught.
      req_valid <= 1'b0;
      while (sb.pending() != 0)
         @(posedge clock);
      repeat (PipeLatency + 16) @(posedge clock);
      sb.close_out();

      if (sb.mismatches == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
